>>> hdl/fasta_scaffold_stats_defines.svh
// ----------------------------------------------------------------------------
// fasta_scaffold_stats_defines
// Assertion macros shared by the checker of the FASTA statistics block.
// ----------------------------------------------------------------------------
`ifndef FASTA_SCAFFOLD_STATS_DEFINES_SVH
`define FASTA_SCAFFOLD_STATS_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define FSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet while rst_n is low
`define FSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Types and constants of the FASTA scaffold statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fss_pkg;

  // name capture limit and name storage
  localparam int NAME_CHARS = 14;
  localparam int NAME_SLOTS = 14;
  localparam int NAME_LEN_W = 4;

  // counter widths
  localparam int LEN_W = 40;
  localparam int CNT_W = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // character codes
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_T  = 8'h54;

  localparam int NUM_BASES = 4;
  localparam logic [7:0] BASE_CHAR [NUM_BASES] = '{CH_A, CH_C, CH_G, CH_T};

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [NAME_LEN_W-1:0] name_len_t;
  typedef logic [NAME_SLOTS-1:0][7:0] name_t;

  // one result beat
  typedef struct packed {
    cnt_t      scaffold_count;
    len_t      longest_length;
    len_t      total_length;
    logic [63:0] name_low;
    logic [47:0] name_high;
    name_len_t name_length;
    len_t      count_a;
    len_t      count_c;
    len_t      count_g;
    len_t      count_t;
  } result_t;

  // core to output buffer
  typedef struct packed {
    logic    vld;
    result_t res;
  } core_out_t;

  // output buffer status back to the input side
  typedef struct packed {
    logic [1:0] occ;
    logic       pop;
  } buf_status_t;

endpackage

>>> hdl/fasta_scaffold_stats.sv
// The block takes a FASTA file one byte per beat and, on the beat marked last,
// returns one result beat with the scaffold count, the longest scaffold's name
// and length, the total length and the A/C/G/T counts; every other byte gives
// nothing. It sustains one byte per cycle while in_stall is low: the byte is
// registered, the parser and counters update in the following cycle, and the
// result beat is taken into the output buffer at that same edge. Results
// wait in a two-entry buffer (output register plus skid register); in_stall
// rises only when that buffer could not take one more result. After the last
// byte all statistics return to zero, so the next byte starts a new file.
// ----------------------------------------------------------------------------
// fasta_scaffold_stats
// Top level: input register, parser core and result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fasta_scaffold_stats (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_req,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_scaffold_count,
  output logic [39:0] out_longest_length,
  output logic [39:0] out_total_length,
  output logic [63:0] out_name_low,
  output logic [47:0] out_name_high,
  output logic [3:0]  out_name_length,
  output logic [39:0] out_count_a,
  output logic [39:0] out_count_c,
  output logic [39:0] out_count_g,
  output logic [39:0] out_count_t
);

  logic                 in_acc;
  logic                 vld_a_r;
  logic [7:0]           byte_a_r;
  logic                 last_a_r;
  logic [1:0]           occ_after;
  fss_pkg::core_out_t   push;
  fss_pkg::result_t     out_res;
  fss_pkg::buf_status_t stat;

  assign in_acc = in_valid & ~in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_a_r <= in_byte_req;
      last_a_r <= in_last;
    end
  end

  // hold input while a new result beat might not fit in the buffer
  always_comb begin
    occ_after = stat.occ - {1'b0, stat.pop} + {1'b0, vld_a_r & last_a_r};
    in_stall  = (occ_after >= 2'd2);
  end

  fss_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .data_vld (vld_a_r),
    .data_in  (byte_a_r),
    .last_in  (last_a_r),
    .push     (push)
  );

  fss_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .stat      (stat)
  );

  // result fields
  assign out_scaffold_count = out_res.scaffold_count;
  assign out_longest_length = out_res.longest_length;
  assign out_total_length   = out_res.total_length;
  assign out_name_low       = out_res.name_low;
  assign out_name_high      = out_res.name_high;
  assign out_name_length    = out_res.name_length;
  assign out_count_a        = out_res.count_a;
  assign out_count_c        = out_res.count_c;
  assign out_count_g        = out_res.count_g;
  assign out_count_t        = out_res.count_t;

endmodule

>>> hdl/fss_out_buf.sv
// ----------------------------------------------------------------------------
// fss_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  fss_pkg::core_out_t  push,
  input  logic                out_stall,
  output logic                out_valid,
  output fss_pkg::result_t    out_res,
  output fss_pkg::buf_status_t stat
);

  logic             out_vld_r, out_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  fss_pkg::result_t out_res_r, out_res_nxt;
  fss_pkg::result_t skid_r, skid_nxt;
  logic             pop;

  assign pop = out_vld_r & ~out_stall;

  // refill the output register from skid first, then from the core
  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_res_nxt  = out_res_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || pop) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_r;
        skid_vld_nxt = push.vld;
        skid_nxt     = push.res;
      end else begin
        out_vld_nxt  = push.vld;
        out_res_nxt  = push.res;
        skid_vld_nxt = 1'b0;
      end
    end else if (push.vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push.res;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    skid_r    <= skid_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;
  assign stat.occ  = {1'b0, out_vld_r} + {1'b0, skid_vld_r};
  assign stat.pop  = pop;

endmodule

>>> hdl/fss_core.sv
// ----------------------------------------------------------------------------
// fss_core
// Per-byte parser state and statistics update, one byte per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fss_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               data_vld,
  input  logic [7:0]         data_in,
  input  logic               last_in,
  output fss_pkg::core_out_t push
);

  // state
  logic               in_header_r, in_header_nxt;
  fss_pkg::len_t      cur_len_r, cur_len_nxt;
  fss_pkg::len_t      best_len_r, best_len_nxt;
  fss_pkg::len_t      sum_len_r, sum_len_nxt;
  fss_pkg::cnt_t      hdr_total_r, hdr_total_nxt;
  fss_pkg::name_t     hdr_chars_r, hdr_chars_nxt;
  fss_pkg::name_len_t hdr_fill_r, hdr_fill_nxt;
  fss_pkg::name_len_t hdr_done_r, hdr_done_nxt;
  fss_pkg::name_t     best_name_r, best_name_nxt;
  fss_pkg::name_len_t best_name_len_r, best_name_len_nxt;
  fss_pkg::len_t      base_cnt_r   [fss_pkg::NUM_BASES];
  fss_pkg::len_t      base_cnt_nxt [fss_pkg::NUM_BASES];

  // working signals
  logic                   is_gt, is_nl, hdr_open, seq, inc_eff, longer, do_close;
  fss_pkg::len_t          cur_inc;
  logic [fss_pkg::LEN_W:0] sum_wide;
  fss_pkg::name_t         name_cand;

  always_comb begin
    is_gt    = (data_in == fss_pkg::CH_GT);
    is_nl    = (data_in == fss_pkg::CH_NL);
    hdr_open = in_header_r | is_gt;

    // header tracking
    in_header_nxt = hdr_open & ~is_nl;
    hdr_total_nxt = hdr_total_r;
    hdr_fill_nxt  = hdr_fill_r;
    hdr_done_nxt  = hdr_done_r;
    hdr_chars_nxt = hdr_chars_r;
    if (hdr_open && is_nl) begin
      if (hdr_total_r != fss_pkg::CNT_MAX) begin
        hdr_total_nxt = hdr_total_r + fss_pkg::CNT_W'(1);
      end
      hdr_done_nxt = hdr_fill_r;
      hdr_fill_nxt = '0;
    end else if (hdr_open && !is_gt &&
                 hdr_fill_r < fss_pkg::NAME_LEN_W'(fss_pkg::NAME_CHARS)) begin
      hdr_chars_nxt[hdr_fill_r] = data_in;
      hdr_fill_nxt = hdr_fill_r + fss_pkg::NAME_LEN_W'(1);
    end

    // sequence symbol: length and base counts
    seq     = ~hdr_open & ~is_nl;
    inc_eff = seq & (cur_len_r != fss_pkg::LEN_MAX);
    cur_inc = cur_len_r + fss_pkg::LEN_W'(inc_eff);
    for (int b = 0; b < fss_pkg::NUM_BASES; b++) begin
      base_cnt_nxt[b] = base_cnt_r[b];
      if (seq && data_in == fss_pkg::BASE_CHAR[b] && base_cnt_r[b] != fss_pkg::LEN_MAX) begin
        base_cnt_nxt[b] = base_cnt_r[b] + fss_pkg::LEN_W'(1);
      end
    end

    // closing a scaffold: compare and sum both fold in the pending increment
    do_close = (is_gt && cur_len_r != '0) || last_in;
    longer   = inc_eff ? (cur_len_r >= best_len_r) : (cur_len_r > best_len_r);
    sum_wide = {1'b0, sum_len_r} + {1'b0, cur_len_r} + (fss_pkg::LEN_W + 1)'(inc_eff);
    for (int i = 0; i < fss_pkg::NAME_SLOTS; i++) begin
      name_cand[i] = (fss_pkg::NAME_LEN_W'(i) < hdr_done_nxt) ? hdr_chars_nxt[i] : 8'h00;
    end

    cur_len_nxt       = cur_inc;
    sum_len_nxt       = sum_len_r;
    best_len_nxt      = best_len_r;
    best_name_nxt     = best_name_r;
    best_name_len_nxt = best_name_len_r;
    if (do_close) begin
      cur_len_nxt = '0;
      sum_len_nxt = sum_wide[fss_pkg::LEN_W] ? fss_pkg::LEN_MAX
                                             : sum_wide[fss_pkg::LEN_W-1:0];
      if (longer) begin
        best_len_nxt      = cur_inc;
        best_name_nxt     = name_cand;
        best_name_len_nxt = hdr_done_nxt;
      end
    end

    // result beat on the final byte
    push.vld                = data_vld & last_in;
    push.res.scaffold_count = hdr_total_nxt;
    push.res.longest_length = best_len_nxt;
    push.res.total_length   = sum_len_nxt;
    push.res.name_low       = best_name_nxt[7:0];
    push.res.name_high      = best_name_nxt[13:8];
    push.res.name_length    = best_name_len_nxt;
    push.res.count_a        = base_cnt_nxt[0];
    push.res.count_c        = base_cnt_nxt[1];
    push.res.count_g        = base_cnt_nxt[2];
    push.res.count_t        = base_cnt_nxt[3];
  end

  // control and statistics state, back to reset after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (data_vld && last_in)) begin
      in_header_r     <= 1'b0;
      cur_len_r       <= '0;
      best_len_r      <= '0;
      sum_len_r       <= '0;
      hdr_total_r     <= '0;
      hdr_fill_r      <= '0;
      hdr_done_r      <= '0;
      best_name_r     <= '0;
      best_name_len_r <= '0;
      for (int b = 0; b < fss_pkg::NUM_BASES; b++) begin
        base_cnt_r[b] <= '0;
      end
    end else if (data_vld) begin
      in_header_r     <= in_header_nxt;
      cur_len_r       <= cur_len_nxt;
      best_len_r      <= best_len_nxt;
      sum_len_r       <= sum_len_nxt;
      hdr_total_r     <= hdr_total_nxt;
      hdr_fill_r      <= hdr_fill_nxt;
      hdr_done_r      <= hdr_done_nxt;
      best_name_r     <= best_name_nxt;
      best_name_len_r <= best_name_len_nxt;
      for (int b = 0; b < fss_pkg::NUM_BASES; b++) begin
        base_cnt_r[b] <= base_cnt_nxt[b];
      end
    end
  end

  // header characters, only read below the completed header length
  always_ff @(posedge clk) begin
    if (data_vld) begin
      hdr_chars_r <= hdr_chars_nxt;
    end
  end

endmodule

>>> hdl/fss_checker.sv
// ----------------------------------------------------------------------------
// fss_checker
// Port-level checks on the FASTA statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fasta_scaffold_stats_defines.svh"

module fss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [39:0] out_longest_length,
  input logic [39:0] out_total_length,
  input logic [63:0] out_name_low,
  input logic [47:0] out_name_high,
  input logic [3:0]  out_name_length
);

  // a stalled result beat holds
  `FSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_longest_length) && $stable(out_name_low) && $stable(out_total_length), "stalled result beat changed")
  // captured name never exceeds the capture limit
  `FSS_ASSERT_NOW(a_name_len, out_valid, out_name_length <= 4'd14, "name length above limit")
  // the longest scaffold is part of the total
  `FSS_ASSERT_NOW(a_longest_in_total, out_valid, out_longest_length <= out_total_length, "longest length above total")
  // an empty name carries no characters
  `FSS_ASSERT_NOW(a_empty_name, out_valid && out_name_length == 4'd0, out_name_low == 64'd0 && out_name_high == 48'd0, "empty name has nonzero bytes")

endmodule

bind fasta_scaffold_stats fss_checker u_fss_checker (.*);
